// ===== hdl/vct_pkg.sv =====
// Shared types, constants and tables for the view camera transform.
// Used by vct_div and view_camera_transform; no dependencies.
`timescale 1ns / 1ps
package vct_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int COORD_FRAC_BITS = 8;

  localparam int DIV_W = 37;
  localparam int DEN_W = 16;

  localparam logic [15:0] SCALE_ONE  = 16'd4096;
  localparam logic [15:0] SCALE_MIN  = 16'd410;
  localparam logic [15:0] SCALE_MAX  = 16'd40960;
  localparam logic [17:0] ANGLE_FULL = 18'd46080;

  localparam logic signed [25:0] DEG16_90  = 26'sd5898240;
  localparam logic signed [25:0] DEG16_180 = 26'sd11796480;
  localparam logic signed [25:0] DEG16_360 = 26'sd23592960;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032875;

  localparam logic [2:0] FN_S2W    = 3'd0;
  localparam logic [2:0] FN_W2S    = 3'd1;
  localparam logic [2:0] FN_ZIN    = 3'd2;
  localparam logic [2:0] FN_ZOUT   = 3'd3;
  localparam logic [2:0] FN_ROTATE = 3'd4;
  localparam logic [2:0] FN_RESET  = 3'd5;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVX, S_DIVY, S_PMUL, S_CORDIC, S_ROT, S_ZMUL, S_ZDIV, S_VIEW, S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [25:0] atan_deg16(input logic [4:0] i);
    logic signed [25:0] r;
    case (i)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] half_view(input logic [13:0] w);
    logic [31:0] t;
    t = {18'd0, w} << (COORD_FRAC_BITS - 1);
    return t[23:0];
  endfunction

endpackage

// ===== hdl/view_camera_transform.sv =====
// View camera: maps points between screen and world and keeps zoom, angle, centre.
// Screen to world runs two divisions, CORDIC, rotate and output steps; one item at a
// time. The shared divider serves both divisions and zoom out; a zero zoom-out factor
// skips the division. The result register lets the next item start while a result
// waits. Synchronous reset: viewport 640x480, scale 1.0, angle 0, centre at half
// viewport. Depends on vct_pkg and vct_div.
`timescale 1ns / 1ps
module view_camera_transform (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [23:0] coord_x,
  input  logic signed [23:0] coord_y,
  input  logic [15:0]        zoom_factor,
  input  logic signed [16:0] angle_delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic [15:0]        cur_scale,
  output logic [15:0]        cur_angle,
  output logic               saturated
);
  import vct_pkg::*;

  state_t state, state_next;

  logic [13:0]        viewport_width, viewport_height;
  logic [15:0]        zoom_scale, view_angle;
  logic signed [23:0] center_x, center_y;

  logic [5:0]         cnt;
  logic [2:0]         op;
  logic signed [23:0] px, py;
  logic [15:0]        fac;
  logic signed [16:0] delta;
  logic signed [29:0] ax, ay;
  logic               dneg;
  logic signed [32:0] cx, cy;
  logic signed [25:0] cz;
  logic               cneg;
  logic signed [62:0] prod, acc;
  logic signed [33:0] rxs, rys;
  logic signed [23:0] res_x, res_y;
  logic               res_sat;

  logic               in_acc, cfg_wr, out_load;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [23:0]        hw_w, hw_h;
  logic signed [24:0] dsx, dsy, dwx, dwy;
  logic [24:0]        magx, magy;
  logic signed [32:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [62:0] rnd12;
  logic signed [63:0] rsum, rrnd;
  logic signed [25:0] z0, z1;
  logic [4:0]         ci;
  logic signed [32:0] sdx, sdy;
  logic [32:0]        zin_t;
  logic [17:0]        ang_m;
  logic [18:0]        ang_s;
  logic signed [34:0] fx, fy;
  logic [24:0]        clx, cly;

  vct_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  function automatic logic [24:0] clip24(input logic signed [34:0] v);
    logic [24:0] r;
    if (v > 35'sd8388607)       r = {1'b1, 24'h7FFFFF};
    else if (v < -35'sd8388608) r = {1'b1, 24'h800000};
    else                        r = {1'b0, v[23:0]};
    return r;
  endfunction

  function automatic logic [15:0] clamp_scale(input logic [36:0] q);
    logic [15:0] r;
    if (q < 37'(SCALE_MIN))      r = SCALE_MIN;
    else if (q > 37'(SCALE_MAX)) r = SCALE_MAX;
    else                         r = q[15:0];
    return r;
  endfunction

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_HEIGHT) ? {18'd0, viewport_height}
                                             : {18'd0, viewport_width};
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    hw_w  = half_view(viewport_width);
    hw_h  = half_view(viewport_height);
    dsx   = {px[23], px} - {1'b0, hw_w};
    dsy   = {py[23], py} - {1'b0, hw_h};
    dwx   = {px[23], px} - {center_x[23], center_x};
    dwy   = {py[23], py} - {center_y[23], center_y};
    magx  = dsx[24] ? 25'(-dsx) : 25'(dsx);
    magy  = dsy[24] ? 25'(-dsy) : 25'(dsy);
    rnd12 = prod + 63'sd2048;
    zin_t = prod[32:0] + 33'd2048;

    div_req.start = (cnt == 6'd0) &&
                    (state == S_DIVX || state == S_DIVY || state == S_ZDIV);
    div_req.num   = '0;
    div_req.den   = zoom_scale;
    case (state)
      S_DIVX:  div_req.num = {magx, 12'd0} + 37'(zoom_scale[15:1]);
      S_DIVY:  div_req.num = {magy, 12'd0} + 37'(zoom_scale[15:1]);
      S_ZDIV: begin
        div_req.num = {9'd0, zoom_scale, 12'd0} + 37'(fac[15:1]);
        div_req.den = fac;
      end
      default: div_req.num = '0;
    endcase

    mul_a = '0;
    mul_b = '0;
    case (state)
      S_PMUL: begin
        mul_a = $signed({17'd0, zoom_scale});
        mul_b = (cnt == 6'd0) ? 30'(dwx) : 30'(dwy);
      end
      S_ZMUL: begin
        mul_a = $signed({17'd0, zoom_scale});
        mul_b = $signed({14'd0, fac});
      end
      S_ROT: begin
        case (cnt)
          6'd0:    begin mul_a = cx; mul_b = ax; end
          6'd1:    begin mul_a = cy; mul_b = ay; end
          6'd2:    begin mul_a = cx; mul_b = ay; end
          6'd3:    begin mul_a = cy; mul_b = ax; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase

    if ((cnt == 6'd2) == (op == FN_W2S))
      rsum = {acc[62], acc} - {prod[62], prod};
    else
      rsum = {acc[62], acc} + {prod[62], prod};
    rrnd = rsum + 64'sd536870912;

    z0 = $signed({1'b0, view_angle, 9'd0});
    z1 = (z0 > DEG16_180) ? z0 - DEG16_360 : z0;
    ci  = 5'(cnt - 6'd1);
    sdx = cy >>> ci;
    sdy = cx >>> ci;

    ang_s = 19'({2'b00, view_angle}) + 19'($signed({delta[16], delta})) + 19'd92160;
    ang_m = ang_s[17:0];
    for (int k = 0; k < 4; k++) begin
      if (ang_m >= ANGLE_FULL) ang_m = ang_m - ANGLE_FULL;
    end

    fx  = (op == FN_S2W) ? 35'(rxs) + 35'(center_x) : 35'(rxs) + 35'($signed({1'b0, hw_w}));
    fy  = (op == FN_S2W) ? 35'(rys) + 35'(center_y) : 35'(rys) + 35'($signed({1'b0, hw_h}));
    clx = clip24(fx);
    cly = clip24(fy);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (func)
            FN_S2W:  state_next = S_DIVX;
            FN_W2S:  state_next = S_PMUL;
            FN_ZIN:  state_next = S_ZMUL;
            FN_ZOUT: state_next = (zoom_factor == 16'd0) ? S_VIEW : S_ZDIV;
            default: state_next = S_VIEW;
          endcase
        end
      end
      S_DIVX:   if (div_rsp.done) state_next = S_DIVY;
      S_DIVY:   if (div_rsp.done) state_next = S_CORDIC;
      S_PMUL:   if (cnt == 6'd2) state_next = S_CORDIC;
      S_CORDIC: if (cnt == 6'(CORDIC_STEPS + 1)) state_next = S_ROT;
      S_ROT:    if (cnt == 6'd5) state_next = S_DONE;
      S_ZMUL:   if (cnt == 6'd1) state_next = S_DONE;
      S_ZDIV:   if (div_rsp.done) state_next = S_DONE;
      S_VIEW:   state_next = S_DONE;
      S_DONE:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_width  <= 14'd640;
      viewport_height <= 14'd480;
      zoom_scale      <= SCALE_ONE;
      view_angle      <= 16'd0;
      center_x        <= $signed(half_view(14'd640));
      center_y        <= $signed(half_view(14'd480));
      out_valid       <= 1'b0;
      cnt             <= 6'd0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_HEIGHT) viewport_height <= pwdata[13:0];
        else                        viewport_width  <= pwdata[13:0];
      end
      if (out_load)                    out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (state != state_next) cnt <= 6'd0;
      else                     cnt <= cnt + 6'd1;
      if ((state == S_DIVX || state == S_DIVY || state == S_ZDIV) && cnt != 6'd0 &&
          state == state_next)
        cnt <= 6'd1;

      case (state)
        S_ZMUL:
          if (cnt == 6'd1) zoom_scale <= clamp_scale({16'd0, zin_t[32:12]});
        S_ZDIV:
          if (div_rsp.done) zoom_scale <= clamp_scale(div_rsp.quo);
        S_VIEW: begin
          case (op)
            FN_ZOUT:   zoom_scale <= SCALE_MAX;
            FN_ROTATE: view_angle <= ang_m[15:0];
            FN_RESET: begin
              zoom_scale <= SCALE_ONE;
              view_angle <= 16'd0;
              center_x   <= $signed(hw_w);
              center_y   <= $signed(hw_h);
            end
            default: zoom_scale <= zoom_scale;
          endcase
        end
        default: zoom_scale <= zoom_scale;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_acc) begin
      op      <= func;
      px      <= coord_x;
      py      <= coord_y;
      fac     <= zoom_factor;
      delta   <= angle_delta;
      res_x   <= '0;
      res_y   <= '0;
      res_sat <= 1'b0;
    end
    case (state)
      S_DIVX: begin
        if (div_req.start) dneg <= dsx[24];
        if (div_rsp.done)  ax <= dneg ? -$signed(div_rsp.quo[29:0]) : $signed(div_rsp.quo[29:0]);
      end
      S_DIVY: begin
        if (div_req.start) dneg <= dsy[24];
        if (div_rsp.done)  ay <= dneg ? -$signed(div_rsp.quo[29:0]) : $signed(div_rsp.quo[29:0]);
      end
      S_PMUL: begin
        if (cnt == 6'd1) ax <= rnd12[41:12];
        if (cnt == 6'd2) ay <= rnd12[41:12];
      end
      S_CORDIC: begin
        if (cnt == 6'd0) begin
          cx <= CORDIC_GAIN;
          cy <= '0;
          if (z1 > DEG16_90) begin
            cz <= z1 - DEG16_180; cneg <= 1'b1;
          end else if (z1 < -DEG16_90) begin
            cz <= z1 + DEG16_180; cneg <= 1'b1;
          end else begin
            cz <= z1; cneg <= 1'b0;
          end
        end else if (cnt <= 6'(CORDIC_STEPS)) begin
          if (!cz[25]) begin
            cx <= cx - sdx; cy <= cy + sdy; cz <= cz - atan_deg16(ci);
          end else begin
            cx <= cx + sdx; cy <= cy - sdy; cz <= cz + atan_deg16(ci);
          end
        end else if (cneg) begin
          cx <= -cx;
          cy <= -cy;
        end
      end
      S_ROT: begin
        case (cnt)
          6'd1:    acc <= prod;
          6'd2:    rxs <= rrnd[63:30];
          6'd3:    acc <= prod;
          6'd4:    rys <= rrnd[63:30];
          6'd5: begin
            res_x   <= $signed(clx[23:0]);
            res_y   <= $signed(cly[23:0]);
            res_sat <= clx[24] | cly[24];
          end
          default: acc <= acc;
        endcase
      end
      default: acc <= acc;
    endcase
    if (out_load) begin
      out_x     <= res_x;
      out_y     <= res_y;
      cur_scale <= zoom_scale;
      cur_angle <= view_angle;
      saturated <= res_sat;
    end
  end

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    zoom_scale >= SCALE_MIN && zoom_scale <= SCALE_MAX)
    else $error("zoom scale out of range");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    {2'b00, view_angle} < ANGLE_FULL)
    else $error("view angle not wrapped");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == S_IDLE)
    else $error("result transfer not presented");

endmodule

// ===== hdl/vct_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vct_pkg.
`timescale 1ns / 1ps
module vct_div (
  input  logic           clk,
  input  logic           rst,
  input  vct_pkg::div_req_t req,
  output vct_pkg::div_rsp_t rsp
);
  import vct_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem, work[DIV_W-1]};
    diff  = trial - {1'b0, den};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.num;
      rem  <= '0;
      den  <= req.den;
    end else if (busy) begin
      work <= {work[DIV_W-2:0], fits};
      rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = work;

endmodule
